// File: src/schroeder_reverb_defines.svh
// Assertion macros used by the reverberator top level.
`ifndef SCHROEDER_REVERB_DEFINES_SVH
`define SCHROEDER_REVERB_DEFINES_SVH
// Concurrent assertion of a property under clock and reset.
`define SRV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assertion that also holds during reset.
`define SRV_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: src/srv_pkg.sv
// Package with types, constants and arithmetic helpers of the reverberator.
`default_nettype none
package srv_pkg;
  localparam int COMB_A_LEN = 3604;
  localparam int COMB_B_LEN = 3114;
  localparam int COMB_C_LEN = 4044;
  localparam int COMB_D_LEN = 4492;
  localparam int ALLPASS_A_LEN = 50;
  localparam int ALLPASS_B_LEN = 16;
  localparam int ALLPASS_C_LEN = 4;
  localparam int NUM_LINES = 7;
  localparam int PTR_W = 13;
  localparam int LINE_W = 3;
  localparam int ADDR_W = 15;
  localparam int MEM_DEPTH = 32768;
  localparam int VAL_W = 20;

  localparam logic [1:0] REG_TIME_SCALE = 2'd0;
  localparam logic [1:0] REG_WET_MIX = 2'd1;
  localparam logic [1:0] REG_COMB_GAIN = 2'd2;
  localparam logic [1:0] REG_ALLPASS_GAIN = 2'd3;

  localparam logic [15:0] TIME_SCALE_RESET = 16'd32768;
  localparam logic [15:0] WET_MIX_RESET = 16'd16384;
  localparam logic [14:0] COMB_GAIN_RESET = 15'd26378;
  localparam logic [14:0] ALLPASS_GAIN_RESET = 15'd22938;
  localparam logic [15:0] Q15_ONE = 16'd32768;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic start;
    logic clear_ptrs;
  } ctl_t;

  function automatic val_t sat20(input logic signed [47:0] x);
    if (x > 48'sd524287) return 20'sd524287;
    if (x < -48'sd524288) return -20'sd524288;
    return x[VAL_W-1:0];
  endfunction
endpackage
`default_nettype wire

// File: src/srv_mem.sv
// Single-port-write, single-port-read delay line memory with registered read.
`default_nettype none
module srv_mem #(
  parameter int DEPTH = srv_pkg::MEM_DEPTH,
  parameter int AW = srv_pkg::ADDR_W
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire srv_pkg::val_t       wdata,
  input  wire logic [AW-1:0]       raddr,
  output srv_pkg::val_t            rdata
);
  srv_pkg::val_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/schroeder_reverb.sv
// Top level of the Schroeder reverberator: control, datapath and line memory.
// A request is processed to the end before the next one can be accepted. Each of the four
// comb lines passes through read, wait, multiply and write states; an averaging state
// follows; each of the three allpass lines passes through read, wait, first multiply,
// second multiply and write states; the output states S_O1, S_O2 and S_O3 follow. The lines
// are processed one after another through a single line memory and one shared multiplier.
// The result register holds a result until it is taken, and a new result waits for it.
// After a time_scale write, requests wait while the active lengths are recomputed, and a
// pending configuration write goes ahead of a request. After reset the block clears its
// 32768-entry line memory before it takes a request; configuration writes are accepted then.
`default_nettype none
`include "schroeder_reverb_defines.svh"
module schroeder_reverb (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] left_sample,
  input  wire logic signed [15:0] right_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      mixed_sample,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_READ = 4'd2,
    S_WAIT = 4'd3, S_M1 = 4'd4, S_M1W = 4'd5, S_M2 = 4'd6, S_M2W = 4'd7,
    S_WRITE = 4'd8, S_AVG = 4'd9, S_O1 = 4'd10, S_O2 = 4'd11, S_O3 = 4'd12,
    S_DONE = 4'd13;

  localparam int BASE0 = 0;
  localparam int BASE1 = BASE0 + srv_pkg::COMB_A_LEN;
  localparam int BASE2 = BASE1 + srv_pkg::COMB_B_LEN;
  localparam int BASE3 = BASE2 + srv_pkg::COMB_C_LEN;
  localparam int BASE4 = BASE3 + srv_pkg::COMB_D_LEN;
  localparam int BASE5 = BASE4 + srv_pkg::ALLPASS_A_LEN;
  localparam int BASE6 = BASE5 + srv_pkg::ALLPASS_B_LEN;
  localparam logic signed [16:0] Q15_ONE_S = 17'sd32768;

  logic [3:0] state;
  logic [15:0] time_scale, wet_mix;
  logic [14:0] comb_gain, allpass_gain;
  srv_pkg::ptr_t ptrs [srv_pkg::NUM_LINES];
  srv_pkg::ptr_t limits [srv_pkg::NUM_LINES];
  logic [2:0] line;
  logic [2:0] lim_idx;
  logic lim_busy;
  logic ts_write;
  logic [srv_pkg::ADDR_W-1:0] clr_addr;
  logic signed [16:0] mono;
  logic signed [23:0] sum;
  srv_pkg::val_t x, y, rd, wv;
  logic signed [40:0] prod;
  logic signed [40:0] acc;
  logic signed [20:0] mul_a;
  logic signed [16:0] mul_b;
  logic mem_we;
  logic [srv_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  srv_pkg::val_t mem_wdata;
  logic signed [40:0] rnd;

  function automatic logic [srv_pkg::ADDR_W-1:0] base_of(input logic [2:0] l);
    case (l)
      3'd0: return srv_pkg::ADDR_W'(BASE0);
      3'd1: return srv_pkg::ADDR_W'(BASE1);
      3'd2: return srv_pkg::ADDR_W'(BASE2);
      3'd3: return srv_pkg::ADDR_W'(BASE3);
      3'd4: return srv_pkg::ADDR_W'(BASE4);
      3'd5: return srv_pkg::ADDR_W'(BASE5);
      default: return srv_pkg::ADDR_W'(BASE6);
    endcase
  endfunction

  function automatic logic [13:0] len_of(input logic [2:0] l);
    case (l)
      3'd0: return 14'(srv_pkg::COMB_A_LEN);
      3'd1: return 14'(srv_pkg::COMB_B_LEN);
      3'd2: return 14'(srv_pkg::COMB_C_LEN);
      3'd3: return 14'(srv_pkg::COMB_D_LEN);
      3'd4: return 14'(srv_pkg::ALLPASS_A_LEN);
      3'd5: return 14'(srv_pkg::ALLPASS_B_LEN);
      default: return 14'(srv_pkg::ALLPASS_C_LEN);
    endcase
  endfunction

  logic is_comb;
  logic [13:0] p_next;
  logic [29:0] lim_prod;
  assign is_comb = (line < 3'd4);
  assign p_next = {1'b0, ptrs[line]} + 14'd1;
  assign lim_prod = time_scale * len_of(lim_idx);
  assign prod = mul_a * mul_b;
  assign rnd = (prod + 41'sd16384) >>> 15;

  srv_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rd)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = base_of(line) + srv_pkg::ADDR_W'(ptrs[line]);
    mem_wdata = wv;
    mem_raddr = base_of(line) + srv_pkg::ADDR_W'(ptrs[line]);
    mul_a = 21'(y);
    mul_b = {2'b00, comb_gain};
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_WRITE: mem_we = 1'b1;
      S_M1: begin
        if (is_comb) mul_a = 21'(rd);
        else begin
          mul_a = 21'(x);
          mul_b = {2'b00, allpass_gain};
        end
      end
      S_M2: mul_b = {2'b00, allpass_gain};
      S_O1: begin
        mul_a = 21'(mono);
        mul_b = Q15_ONE_S - {1'b0, wet_mix};
      end
      S_O2: begin
        mul_a = 21'(x);
        mul_b = {1'b0, wet_mix};
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !lim_busy && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign ts_write = cfg_valid && cfg_ready && (cfg_index == srv_pkg::REG_TIME_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      time_scale <= srv_pkg::TIME_SCALE_RESET;
      wet_mix <= srv_pkg::WET_MIX_RESET;
      comb_gain <= srv_pkg::COMB_GAIN_RESET;
      allpass_gain <= srv_pkg::ALLPASS_GAIN_RESET;
      lim_busy <= 1'b1;
      lim_idx <= '0;
      line <= '0;
      for (int i = 0; i < srv_pkg::NUM_LINES; i++) ptrs[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (lim_busy && !ts_write) begin
        limits[lim_idx] <= lim_prod[15 +: srv_pkg::PTR_W];
        lim_idx <= lim_idx + 3'd1;
        if (lim_idx == 3'(srv_pkg::NUM_LINES - 1)) lim_busy <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          srv_pkg::REG_TIME_SCALE: begin
            time_scale <= (cfg_data > srv_pkg::Q15_ONE) ? srv_pkg::Q15_ONE : cfg_data;
            lim_busy <= 1'b1;
            lim_idx <= '0;
            for (int i = 0; i < srv_pkg::NUM_LINES; i++) ptrs[i] <= '0;
          end
          srv_pkg::REG_WET_MIX:
            wet_mix <= (cfg_data > srv_pkg::Q15_ONE) ? srv_pkg::Q15_ONE : cfg_data;
          srv_pkg::REG_COMB_GAIN: comb_gain <= cfg_data[14:0];
          default: allpass_gain <= cfg_data[14:0];
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 15'd1;
          if (clr_addr == srv_pkg::ADDR_W'(srv_pkg::MEM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          mono <= 17'((18'(left_sample) + 18'(right_sample)) >>> 1);
          x <= 20'(17'((18'(left_sample) + 18'(right_sample)) >>> 1));
          sum <= '0;
          line <= '0;
          state <= S_READ;
        end
        S_READ: state <= S_WAIT;
        S_WAIT: state <= S_M1;
        S_M1: begin
          if (is_comb) begin
            wv <= srv_pkg::sat20(48'(rnd) + 48'(x));
            sum <= sum + 24'(rd);
            state <= S_WRITE;
          end else begin
            y <= srv_pkg::sat20(48'(rd) - 48'(rnd));
            state <= S_M2;
          end
        end
        S_M2: begin
          wv <= srv_pkg::sat20(48'(rnd) + 48'(x));
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (p_next == 14'(limits[line]) || p_next >= len_of(line)) ptrs[line] <= '0;
          else ptrs[line] <= p_next[srv_pkg::PTR_W-1:0];
          if (line == 3'(srv_pkg::NUM_LINES - 1)) line <= '0;
          else line <= line + 3'd1;
          if (line == 3'd3) state <= S_AVG;
          else if (line == 3'(srv_pkg::NUM_LINES - 1)) state <= S_O1;
          else begin
            if (!is_comb) x <= y;
            state <= S_READ;
          end
          if (line == 3'(srv_pkg::NUM_LINES - 1)) x <= y;
        end
        S_AVG: begin
          x <= srv_pkg::sat20(48'((sum + 24'sd2) >>> 2));
          state <= S_READ;
        end
        S_O1: begin
          acc <= prod;
          state <= S_O2;
        end
        S_O2: begin
          acc <= (acc + prod + 41'sd16384) >>> 15;
          state <= S_O3;
        end
        S_O3: if (!out_valid) begin
          mixed_sample <= (acc > 41'sd32767) ? 16'sh7fff :
                          (acc < -41'sd32768) ? 16'sh8000 : acc[15:0];
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `SRV_ASSERT(a_no_accept_busy, clk, rst, (in_valid && in_ready) |-> (state == S_IDLE), "busy")
  `SRV_ASSERT(a_out_from_o3, clk, rst, $rose(out_valid) |-> $past(state) == S_O3, "stray result")
  `SRV_ASSERT(a_line_range, clk, rst, line < 3'(srv_pkg::NUM_LINES), "line out of range")
endmodule
`default_nettype wire
